// ===== hdl/tlls_pkg.sv =====
//----------------------------------------------------------------------------
// Text line lint scanner package
// Request and response types, issue codes, character constants, CSR indices and reset limits.
//----------------------------------------------------------------------------
`default_nettype none

package tlls_pkg;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;

   localparam logic [1:0] ISSUE_LINE_TOO_LONG   = 2'd0;
   localparam logic [1:0] ISSUE_TRAILING_SPACE  = 2'd1;
   localparam logic [1:0] ISSUE_EXCESS_BLANKS   = 2'd2;
   localparam logic [1:0] ISSUE_DOCUMENT_EMPTY  = 2'd3;

   localparam logic CSR_MAX_LINE_LENGTH = 1'b0;
   localparam logic CSR_MAX_BLANK_RUN   = 1'b1;

   localparam logic [15:0] MAX_LINE_LENGTH_RESET = 16'd200;
   localparam logic [7:0]  MAX_BLANK_RUN_RESET   = 8'd2;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [1:0]  issue_code;
      logic        is_error;
      logic [31:0] line_number;
      logic [15:0] measured_length;
      logic        last_of_run;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hdl/text_line_lint_scanner.sv =====
//----------------------------------------------------------------------------
// Text line lint scanner
// Scans text one byte per request and reports long lines, trailing
// whitespace, excessive blank runs and empty documents.
//----------------------------------------------------------------------------
// Each result is registered in the result queue before it is presented.
// Throughput: one request per cycle while req_stall is low; results leave at one per cycle while rsp_stall is low.
// A four-entry result queue stalls requests while it holds more than two.
// Reset is synchronous: it clears the scan state and the result queue and
// restores the limits to 200 and 2.
`default_nettype none

module text_line_lint_scanner
   import tlls_pkg::*;
#(
   parameter int LENGTH_BITS = 16,
   parameter int LINE_BITS   = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire req_type     req_data,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      rsp_type     rsp_data
);

   localparam int LINE_WIDE = (LINE_BITS > 32) ? LINE_BITS : 32;
   localparam int LEN_WIDE  = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

   logic [15:0]            max_len_ff;
   logic [7:0]             max_blank_ff;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [LENGTH_BITS-1:0] length_ff, length_in;
   logic [7:0]             prev_ff, prev_in;
   logic [7:0]             blank_ff, blank_in;
   logic                   seen_ff, seen_in;
   logic                   skip_ff, skip_in;
   rsp_type                slot_ff [4];
   rsp_type                slot_in [4];
   logic [2:0]             count_ff, count_in;

   logic                   req_fire;
   logic                   rsp_pop;
   logic [2:0]             base;
   logic [1:0]             num_res;
   rsp_type                res0, res1;
   logic [LINE_WIDE-1:0]   line_wide;
   logic [LEN_WIDE-1:0]    len_wide;
   logic [31:0]            line_rep;
   logic [15:0]            len_rep;
   logic [LINE_BITS-1:0]   line_adv;
   logic [7:0]             blank_inc;
   logic                   too_long, trailing, blank_rep;

   assign req_stall = (count_ff > 3'd2);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_data  = slot_ff[0];
   assign rsp_pop   = rsp_valid && !rsp_stall;

   assign line_wide = LINE_WIDE'(line_ff);
   assign len_wide  = LEN_WIDE'(length_ff);
   assign line_rep  = (line_wide > LINE_WIDE'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                              : line_wide[31:0];
   assign len_rep   = (len_wide > LEN_WIDE'(16'hFFFF)) ? 16'hFFFF : len_wide[15:0];
   assign line_adv  = (line_ff == '1) ? line_ff : line_ff + 1'b1;
   assign blank_inc = (blank_ff == 8'hFF) ? blank_ff : blank_ff + 8'd1;

   assign too_long  = (len_wide > LEN_WIDE'(max_len_ff));
   assign trailing  = (length_ff != '0) &&
                      ((prev_ff == CHAR_SPACE) || (prev_ff == CHAR_TAB));
   assign blank_rep = (length_ff == '0) && (blank_inc > max_blank_ff);

   always_comb begin
      rsp_type r_long, r_trail, r_blank, r_empty;

      r_long  = '{issue_code: ISSUE_LINE_TOO_LONG, is_error: 1'b0,
                  line_number: line_rep, measured_length: len_rep,
                  last_of_run: !trailing};
      r_trail = '{issue_code: ISSUE_TRAILING_SPACE, is_error: 1'b0,
                  line_number: line_rep, measured_length: 16'd0,
                  last_of_run: 1'b1};
      r_blank = '{issue_code: ISSUE_EXCESS_BLANKS, is_error: 1'b0,
                  line_number: line_rep, measured_length: 16'd0,
                  last_of_run: 1'b1};
      r_empty = '{issue_code: ISSUE_DOCUMENT_EMPTY, is_error: 1'b1,
                  line_number: 32'd1, measured_length: 16'd0,
                  last_of_run: 1'b1};

      line_in   = line_ff;
      length_in = length_ff;
      prev_in   = prev_ff;
      blank_in  = blank_ff;
      seen_in   = seen_ff;
      skip_in   = skip_ff;
      num_res   = 2'd0;
      res0      = r_trail;
      res1      = r_trail;

      if (req_data.end_of_text) begin
         res0      = r_empty;
         num_res   = seen_ff ? 2'd0 : 2'd1;
         line_in   = LINE_BITS'(1);
         length_in = '0;
         prev_in   = 8'd0;
         blank_in  = 8'd0;
         seen_in   = 1'b0;
         skip_in   = 1'b0;
      end else if (req_data.text_byte == CHAR_NEWLINE) begin
         prev_in = req_data.text_byte;
         line_in = line_adv;
         if (!skip_ff) begin
            length_in = '0;
            if (too_long) begin
               res0    = r_long;
               num_res = trailing ? 2'd2 : 2'd1;
            end else if (trailing) begin
               res0    = r_trail;
               num_res = 2'd1;
            end else if (blank_rep) begin
               res0    = r_blank;
               num_res = 2'd1;
            end
            if (length_ff == '0) begin
               blank_in = blank_inc;
               skip_in  = blank_rep;
            end else begin
               blank_in = 8'd0;
               seen_in  = 1'b1;
            end
         end
      end else begin
         skip_in   = 1'b0;
         prev_in   = req_data.text_byte;
         length_in = (length_ff == '1) ? length_ff : length_ff + 1'b1;
      end

      if (!req_fire) begin
         num_res = 2'd0;
      end
   end

   assign base     = count_ff - {2'b00, rsp_pop};
   assign count_in = base + {1'b0, num_res};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         slot_in[i] = rsp_pop ? slot_ff[i+1] : slot_ff[i];
      end
      slot_in[3] = slot_ff[3];
      for (int i = 0; i < 4; i++) begin
         if ((num_res != 2'd0) && (base == 3'(i))) begin
            slot_in[i] = res0;
         end
         if ((num_res == 2'd2) && (base + 3'd1 == 3'(i))) begin
            slot_in[i] = res1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= MAX_LINE_LENGTH_RESET;
         max_blank_ff <= MAX_BLANK_RUN_RESET;
         line_ff      <= LINE_BITS'(1);
         length_ff    <= '0;
         prev_ff      <= 8'd0;
         blank_ff     <= 8'd0;
         seen_ff      <= 1'b0;
         skip_ff      <= 1'b0;
         count_ff     <= 3'd0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_MAX_LINE_LENGTH) begin
               max_len_ff <= csr_wdata;
            end else begin
               max_blank_ff <= csr_wdata[7:0];
            end
         end
         if (req_fire) begin
            line_ff   <= line_in;
            length_ff <= length_in;
            prev_ff   <= prev_in;
            blank_ff  <= blank_in;
            seen_ff   <= seen_in;
            skip_ff   <= skip_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/tlls_checker.sv =====
//----------------------------------------------------------------------------
// Text line lint scanner checker
// Port-level properties of the scanner, bound to the scanner module.
//----------------------------------------------------------------------------
`default_nettype none

module tlls_checker
   import tlls_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   a_reset_empty: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp_valid)
      else $error("Response valid right after reset.");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("Stalled response changed.");

   a_error_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.is_error == (rsp_data.issue_code == ISSUE_DOCUMENT_EMPTY)))
      else $error("Error severity does not match the issue code.");

   a_empty_doc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.issue_code == ISSUE_DOCUMENT_EMPTY)) |->
      ((rsp_data.line_number == 32'd1) && rsp_data.last_of_run))
      else $error("Empty document response is malformed.");

   a_length_field: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.issue_code == ISSUE_LINE_TOO_LONG) ==
                     (rsp_data.measured_length != 16'd0)))
      else $error("Measured length does not match the issue code.");

endmodule

bind text_line_lint_scanner tlls_checker u_tlls_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
